// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the IR frame decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset
`define IRDEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Expression must never be true outside reset
`define IRDEC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

// ===== hdl/irdec_pkg.sv =====
// ----------------------------------------------------------------------------
// irdec_pkg
// Types, protocol timing windows and codes for the IR frame decoder.
// ----------------------------------------------------------------------------
package irdec_pkg;

  localparam int unsigned NumLanes = 5;
  localparam int unsigned DurW     = 16;
  localparam int unsigned CodeW    = 48;
  localparam int unsigned BitsW    = 7;

  localparam logic [BitsW-1:0] BitsSat = 7'd127;

  // NEC repeat code leader window
  localparam logic [DurW-1:0] RptMarkLo  = 16'd8000;
  localparam logic [DurW-1:0] RptMarkHi  = 16'd10000;
  localparam logic [DurW-1:0] RptSpaceLo = 16'd1800;
  localparam logic [DurW-1:0] RptSpaceHi = 16'd2800;

  // Sony accepted frame lengths
  localparam logic [BitsW-1:0] SonyLen12 = 7'd12;
  localparam logic [BitsW-1:0] SonyLen15 = 7'd15;
  localparam logic [BitsW-1:0] SonyLen20 = 7'd20;

  typedef enum logic [1:0] {
    ST_NOISE   = 2'd0,
    ST_REPEAT  = 2'd1,
    ST_DECODED = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PR_NEC       = 3'd0,
    PR_SAMSUNG   = 3'd1,
    PR_JVC       = 3'd2,
    PR_PANASONIC = 3'd3,
    PR_SONY      = 3'd4
  } proto_e;

  // Per-protocol leader windows, bit total and bit threshold.
  // pulse_width lanes sample marks and accept the Sony lengths.
  typedef struct packed {
    logic [DurW-1:0]  mark_lo;
    logic [DurW-1:0]  mark_hi;
    logic [DurW-1:0]  space_lo;
    logic [DurW-1:0]  space_hi;
    logic [BitsW-1:0] total;
    logic [DurW-1:0]  thresh;
    logic             pulse_width;
  } lane_spec_t;

  localparam lane_spec_t LaneSpecs [NumLanes] = '{
    '{16'd8000, 16'd10000, 16'd4000, 16'd5000, 7'd32, 16'd1000, 1'b0},
    '{16'd3900, 16'd5100,  16'd3900, 16'd5100, 7'd32, 16'd1000, 1'b0},
    '{16'd7700, 16'd9000,  16'd3700, 16'd4700, 7'd16, 16'd1000, 1'b0},
    '{16'd3000, 16'd3900,  16'd1450, 16'd2050, 7'd48, 16'd900,  1'b0},
    '{16'd2000, 16'd2800,  16'd350,  16'd850,  7'd0,  16'd900,  1'b1}
  };

  // Per-pulse control broadcast to all lanes
  typedef struct packed {
    logic take;
    logic clear;
    logic mark_slot;
    logic space_slot;
  } lane_ctl_t;

  // One end-of-frame report
  typedef struct packed {
    status_e          status;
    proto_e           protocol;
    logic [5:0]       bit_count;
    logic [CodeW-1:0] code;
    logic [7:0]       pulse_count;
    logic [DurW-1:0]  leader_mark;
    logic [DurW-1:0]  leader_space;
  } frame_res_t;

endpackage

// ===== hdl/irdec_lane.sv =====
// ----------------------------------------------------------------------------
// irdec_lane
// One protocol shift lane: samples the pulses of its slot kind, thresholds
// them into bits and keeps a saturating bit count.
// ----------------------------------------------------------------------------
module irdec_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  irdec_pkg::lane_ctl_t              ctl_i,
  input  irdec_pkg::lane_spec_t             spec_i,
  input  logic [irdec_pkg::DurW-1:0]        dur_i,
  output logic [irdec_pkg::CodeW-1:0]       shift_o,
  output logic [irdec_pkg::BitsW-1:0]       bits_o
);

  logic [irdec_pkg::CodeW-1:0] shift_q;
  logic [irdec_pkg::BitsW-1:0] bits_q;
  logic                        sample;
  logic                        bit_in;

  // Mark lanes take the even slots after the leader; space lanes stop at their total
  always_comb begin
    sample = ctl_i.take & (spec_i.pulse_width ? ctl_i.mark_slot
                                              : (ctl_i.space_slot & (bits_q < spec_i.total)));
    bit_in = (dur_i > spec_i.thresh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      bits_q  <= '0;
    end else if (ctl_i.clear) begin
      shift_q <= '0;
      bits_q  <= '0;
    end else if (sample) begin
      shift_q <= {shift_q[irdec_pkg::CodeW-2:0], bit_in};
      if (bits_q != irdec_pkg::BitsSat) begin
        bits_q <= bits_q + 7'd1;
      end
    end
  end

  assign shift_o = shift_q;
  assign bits_o  = bits_q;

endmodule

// ===== hdl/irdec_classify.sv =====
// ----------------------------------------------------------------------------
// irdec_classify
// End-of-frame decision: noise, NEC repeat, first matching protocol lane,
// or unknown frame.
// ----------------------------------------------------------------------------
module irdec_classify (
  input  logic                          few_pulses_i,
  input  logic [7:0]                    pulse_count_i,
  input  logic [irdec_pkg::DurW-1:0]    leader_mark_i,
  input  logic [irdec_pkg::DurW-1:0]    leader_space_i,
  input  logic [irdec_pkg::CodeW-1:0]   lane_shift_i [irdec_pkg::NumLanes],
  input  logic [irdec_pkg::BitsW-1:0]   lane_bits_i  [irdec_pkg::NumLanes],
  output irdec_pkg::frame_res_t         res_o
);

  logic [irdec_pkg::NumLanes-1:0] lead_hit;
  logic [irdec_pkg::NumLanes-1:0] len_ok;
  logic                           is_repeat;

  // Leader window and bit length checks per lane
  always_comb begin
    for (int p = 0; p < irdec_pkg::NumLanes; p++) begin
      lead_hit[p] = (leader_mark_i  >= irdec_pkg::LaneSpecs[p].mark_lo)  &&
                    (leader_mark_i  <= irdec_pkg::LaneSpecs[p].mark_hi)  &&
                    (leader_space_i >= irdec_pkg::LaneSpecs[p].space_lo) &&
                    (leader_space_i <= irdec_pkg::LaneSpecs[p].space_hi);
      if (irdec_pkg::LaneSpecs[p].pulse_width) begin
        len_ok[p] = (lane_bits_i[p] == irdec_pkg::SonyLen12) ||
                    (lane_bits_i[p] == irdec_pkg::SonyLen15) ||
                    (lane_bits_i[p] == irdec_pkg::SonyLen20);
      end else begin
        len_ok[p] = (lane_bits_i[p] == irdec_pkg::LaneSpecs[p].total);
      end
    end
    is_repeat = (leader_mark_i  >= irdec_pkg::RptMarkLo)  &&
                (leader_mark_i  <= irdec_pkg::RptMarkHi)  &&
                (leader_space_i >= irdec_pkg::RptSpaceLo) &&
                (leader_space_i <= irdec_pkg::RptSpaceHi);
  end

  // Outcome priority: noise, repeat, lanes in table order
  always_comb begin
    logic found;
    found              = 1'b0;
    res_o.status       = irdec_pkg::ST_UNKNOWN;
    res_o.protocol     = irdec_pkg::PR_NEC;
    res_o.bit_count    = '0;
    res_o.code         = '0;
    res_o.pulse_count  = pulse_count_i;
    res_o.leader_mark  = leader_mark_i;
    res_o.leader_space = leader_space_i;
    priority if (few_pulses_i) begin
      res_o.status = irdec_pkg::ST_NOISE;
    end else if (is_repeat) begin
      res_o.status = irdec_pkg::ST_REPEAT;
    end else begin
      for (int p = 0; p < irdec_pkg::NumLanes; p++) begin
        if (!found && lead_hit[p] && len_ok[p]) begin
          found           = 1'b1;
          res_o.status    = irdec_pkg::ST_DECODED;
          res_o.protocol  = irdec_pkg::proto_e'(3'(p));
          res_o.bit_count = lane_bits_i[p][5:0];
          res_o.code      = lane_shift_i[p];
        end
      end
    end
  end

endmodule

// ===== hdl/ir_remote_frame_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// ir_remote_frame_decoder_unit
// IR remote frame decoder for NEC, Samsung, JVC, Panasonic and Sony frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: one request per demodulated pulse width (tuser = 0,
//   tdata = width in us), alternating mark and space from the leader mark.
//   A request with tuser = 1 marks the idle gap that ends the frame; its
//   tdata is ignored. Pulses beyond MAX_PULSES in one frame are dropped.
//   Output stream m_axis: one request per frame end carrying the outcome
//   (tuser) and the decoded code, bit count, pulse count and leader pair.
//   Throughput: one request per clock unless a frame end waits on a result;
//   the limit is the single register stage in front of the five lane updates.
//   A frame end raises m_axis_tvalid once it moves from the input stage into
//   the output register; pulses produce no output.
//   Reset clears the input and output valid flags and all frame state.
//   When the receiver stalls, the result waits in the output register while
//   further pulses keep flowing; a second frame end waits in the input stage
//   and s_axis_tready drops until the pending result has been taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ir_remote_frame_decoder_unit #(
  parameter int unsigned MAX_PULSES = 200
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,  // [15:0] duration
  input  logic [0:0]   s_axis_tuser,  // [0] operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] protocol, [8:3] bit_count, [56:9] code, [64:57] pulse_count,
  // [80:65] leader_mark, [96:81] leader_space, [103:97] zero
  output logic [103:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser   // [1:0] status
);

  localparam int unsigned CntW = $clog2(MAX_PULSES + 1);

  // Input stage
  logic                        in_valid_q;
  logic                        in_op_q;
  logic [irdec_pkg::DurW-1:0]  in_dur_q;

  // Frame state
  logic [irdec_pkg::DurW-1:0]  lm_q;
  logic [irdec_pkg::DurW-1:0]  ls_q;
  logic [CntW-1:0]             cnt_q;

  // Output register
  logic                        out_valid_q;
  irdec_pkg::frame_res_t       out_res_q;

  logic                        adv;
  logic                        end_fire;
  logic                        pulse_take;
  irdec_pkg::lane_ctl_t        lane_ctl;
  logic [irdec_pkg::CodeW-1:0] lane_shift [irdec_pkg::NumLanes];
  logic [irdec_pkg::BitsW-1:0] lane_bits  [irdec_pkg::NumLanes];
  irdec_pkg::frame_res_t       frame_res;

  // Stage advance: pulses always go, a frame end needs a free result slot
  always_comb begin
    adv           = in_valid_q & (~in_op_q | ~out_valid_q | m_axis_tready);
    end_fire      = adv & in_op_q;
    pulse_take    = adv & ~in_op_q & (cnt_q < CntW'(MAX_PULSES));
    s_axis_tready = ~in_valid_q | adv;
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q  <= s_axis_tuser[0];
      in_dur_q <= s_axis_tdata;
    end
  end

  // Slot decode for the lanes
  always_comb begin
    lane_ctl.take       = pulse_take;
    lane_ctl.clear      = end_fire;
    lane_ctl.mark_slot  = (cnt_q >= CntW'(2)) & ~cnt_q[0];
    lane_ctl.space_slot = (cnt_q >= CntW'(3)) & cnt_q[0];
  end

  // Leader pair and pulse count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lm_q  <= '0;
      ls_q  <= '0;
      cnt_q <= '0;
    end else if (end_fire) begin
      lm_q  <= '0;
      ls_q  <= '0;
      cnt_q <= '0;
    end else if (pulse_take) begin
      if (cnt_q == CntW'(0)) begin
        lm_q <= in_dur_q;
      end
      if (cnt_q == CntW'(1)) begin
        ls_q <= in_dur_q;
      end
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  // Protocol lanes
  for (genvar g = 0; g < irdec_pkg::NumLanes; g++) begin : g_lane
    irdec_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (lane_ctl),
      .spec_i  (irdec_pkg::LaneSpecs[g]),
      .dur_i   (in_dur_q),
      .shift_o (lane_shift[g]),
      .bits_o  (lane_bits[g])
    );
  end

  irdec_classify u_classify (
    .few_pulses_i   (cnt_q < CntW'(4)),
    .pulse_count_i  (8'(cnt_q)),
    .leader_mark_i  (lm_q),
    .leader_space_i (ls_q),
    .lane_shift_i   (lane_shift),
    .lane_bits_i    (lane_bits),
    .res_o          (frame_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (end_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_fire) begin
      out_res_q <= frame_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.status;
  assign m_axis_tdata  = {7'd0,
                          out_res_q.leader_space,
                          out_res_q.leader_mark,
                          out_res_q.pulse_count,
                          out_res_q.code,
                          out_res_q.bit_count,
                          out_res_q.protocol};

  // Checks
  `IRDEC_ASSERT(a_result_from_frame_end, $rose(out_valid_q) |-> $past(end_fire), "result without frame end")
  `IRDEC_ASSERT(a_clear_after_end, end_fire |=> (cnt_q == '0) && (lm_q == '0), "frame state not cleared")
  `IRDEC_ASSERT_NEVER(a_store_limit, cnt_q > CntW'(MAX_PULSES), "pulse count beyond store limit")
  `IRDEC_ASSERT(a_code_only_decoded, (out_valid_q && (out_res_q.status != irdec_pkg::ST_DECODED)) |-> ((out_res_q.code == '0) && (out_res_q.bit_count == '0)), "code on non-decoded result")

endmodule
